@@ rtl/vstc_pkg.sv @@
`timescale 1ns / 1ps

package vstc_pkg;

  // field widths
  localparam int CLK_W      = 32;
  localparam int LIM_W      = 20;
  localparam int BG_W       = 20;
  localparam int SINCE_W    = 16;
  localparam int ANGLE_BITS = 12;
  localparam int TOL_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // timing
  localparam int TICK_MS_DEF    = 100;
  localparam int DIR_FRESH_MS   = 1000;
  localparam int SRC_AGE_MAX_MS = 500;
  localparam int RING_SPEECH_MS = 400;
  localparam logic [BG_W-1:0] BG_MAX = {BG_W{1'b1}};

  // register reset values
  localparam logic [LIM_W-1:0] SILENCE_RST   = LIM_W'(2000);
  localparam logic [LIM_W-1:0] NO_SPEECH_RST = LIM_W'(8000);
  localparam logic [LIM_W-1:0] MAX_SESS_RST  = LIM_W'(60000);
  localparam logic [TOL_W-1:0] TOL_RST       = TOL_W'(455);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SILENCE   = 3'd0,
    CFG_NO_SPEECH = 3'd1,
    CFG_MAX_SESS  = 3'd2,
    CFG_PIN_EN    = 3'd3,
    CFG_FILT_EN   = 3'd4,
    CFG_TOL       = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_SILENCE   = 3'd1,
    CAUSE_NO_SPEECH = 3'd2,
    CAUSE_TOO_LONG  = 3'd3,
    CAUSE_LINK_LOST = 3'd4
  } cause_t;

  typedef enum logic [1:0] {
    RING_NONE   = 2'd0,
    RING_WAKE   = 2'd1,
    RING_SPEECH = 2'd2
  } ring_t;

  typedef struct packed {
    logic                  wake_event;
    logic                  room_link_up;
    logic                  timer_ringing;
    logic [SINCE_W-1:0]    since_speech_ms;
    logic [ANGLE_BITS-1:0] fixed_angle;
    logic                  fixed_angle_ok;
    logic [ANGLE_BITS-1:0] auto_angle;
    logic                  auto_angle_ok;
  } in_word_t;

  typedef struct packed {
    logic                  session_on;
    logic                  session_opened;
    cause_t                close_cause;
    ring_t                 ring_stop;
    logic                  wake_rejected;
    logic                  pin_command;
    logic                  unpin_command;
    logic [ANGLE_BITS-1:0] pin_angle;
    logic [ANGLE_BITS-1:0] shown_angle;
    logic                  shown_angle_ok;
    logic                  speaker_heard;
    logic [BG_W-1:0]       background_ms;
  } out_word_t;

endpackage

@@ rtl/voice_session_timeout_controller_top.sv @@
`timescale 1ns / 1ps

// Voice session timeout controller. Each input word is one tick of TICK_MS
// milliseconds; each produces exactly one result word. Words pass through an
// input register, then session logic that updates the state and loads the
// result register, so a word can be taken every cycle while the result
// register is free or being drained; a result waits on out_* while out_ready
// is held low. The combinational state update between the two registers
// sets that one-word-per-cycle rate. Configuration writes through cfg_we/
// cfg_index/cfg_wdata take effect at once; write only while no word is in
// flight. Indexes above 5 are ignored. close_cause and ring_stop use the
// codes of vstc_pkg::cause_t and vstc_pkg::ring_t.

module voice_session_timeout_controller_top #(
  parameter int TICK_MS = vstc_pkg::TICK_MS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_wake_event,
  input  logic                            in_room_link_up,
  input  logic                            in_timer_ringing,
  input  logic [vstc_pkg::SINCE_W-1:0]    in_since_speech_ms,
  input  logic [vstc_pkg::ANGLE_BITS-1:0] in_fixed_angle,
  input  logic                            in_fixed_angle_ok,
  input  logic [vstc_pkg::ANGLE_BITS-1:0] in_auto_angle,
  input  logic                            in_auto_angle_ok,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_session_on,
  output logic                            out_session_opened,
  output logic [2:0]                      out_close_cause,
  output logic [1:0]                      out_ring_stop,
  output logic                            out_wake_rejected,
  output logic                            out_pin_command,
  output logic                            out_unpin_command,
  output logic [vstc_pkg::ANGLE_BITS-1:0] out_pin_angle,
  output logic [vstc_pkg::ANGLE_BITS-1:0] out_shown_angle,
  output logic                            out_shown_angle_ok,
  output logic                            out_speaker_heard,
  output logic [vstc_pkg::BG_W-1:0]       out_background_ms,

  input  logic                            cfg_we,
  input  logic [vstc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vstc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = vstc_pkg::CLK_W;
  localparam int AW = vstc_pkg::ANGLE_BITS;
  localparam int BW = vstc_pkg::BG_W;
  localparam int LW = vstc_pkg::LIM_W;
  localparam int SW = vstc_pkg::SINCE_W;

  localparam logic [CW-1:0] TICK        = CW'(TICK_MS);
  localparam logic [SW:0]   SPEECH_LIM  = (SW + 1)'(2 * TICK_MS);
  localparam logic [SW:0]   RING_LIM    = (SW + 1)'(vstc_pkg::RING_SPEECH_MS);
  localparam logic [CW-1:0] DIR_FRESH   = CW'(vstc_pkg::DIR_FRESH_MS);
  localparam logic [CW-1:0] SRC_FRESH   = CW'(vstc_pkg::SRC_AGE_MAX_MS);
  localparam logic [BW:0]   BG_TICK     = (BW + 1)'(TICK_MS);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [LW-1:0]                silence_lim_r, no_speech_lim_r, max_sess_r;
  logic                         pin_en_r, filt_en_r;
  logic [vstc_pkg::TOL_W-1:0]   tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_lim_r   <= vstc_pkg::SILENCE_RST;
      no_speech_lim_r <= vstc_pkg::NO_SPEECH_RST;
      max_sess_r      <= vstc_pkg::MAX_SESS_RST;
      pin_en_r        <= 1'b1;
      filt_en_r       <= 1'b0;
      tol_r           <= vstc_pkg::TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vstc_pkg::CFG_SILENCE:   silence_lim_r   <= cfg_wdata[LW-1:0];
        vstc_pkg::CFG_NO_SPEECH: no_speech_lim_r <= cfg_wdata[LW-1:0];
        vstc_pkg::CFG_MAX_SESS:  max_sess_r      <= cfg_wdata[LW-1:0];
        vstc_pkg::CFG_PIN_EN:    pin_en_r        <= cfg_wdata[0];
        vstc_pkg::CFG_FILT_EN:   filt_en_r       <= cfg_wdata[0];
        vstc_pkg::CFG_TOL:       tol_r           <= cfg_wdata[vstc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register and result register handshake
  // ---------------------------------------------------------------------
  vstc_pkg::in_word_t  in_word_r;
  vstc_pkg::out_word_t out_word_r, out_word_nxt;
  logic                in_full_r, out_valid_r;
  logic                step;

  // a word moves on when the result register is free or being drained
  assign step     = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_full_r <= in_valid;
      if (step) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r.wake_event      <= in_wake_event;
      in_word_r.room_link_up    <= in_room_link_up;
      in_word_r.timer_ringing   <= in_timer_ringing;
      in_word_r.since_speech_ms <= in_since_speech_ms;
      in_word_r.fixed_angle     <= in_fixed_angle;
      in_word_r.fixed_angle_ok  <= in_fixed_angle_ok;
      in_word_r.auto_angle      <= in_auto_angle;
      in_word_r.auto_angle_ok   <= in_auto_angle_ok;
    end
    if (step) out_word_r <= out_word_nxt;
  end

  // ---------------------------------------------------------------------
  // Session state
  // ---------------------------------------------------------------------
  logic [CW-1:0] clock_r, start_r, last_speech_r, last_dir_r, src_time_r;
  logic [CW-1:0] clock_nxt, start_nxt, last_speech_nxt, last_dir_nxt, src_time_nxt;
  logic [AW-1:0] tracked_r, pinned_r, src_angle_r;
  logic [AW-1:0] tracked_nxt, pinned_nxt, src_angle_nxt;
  logic          active_r, tracked_ok_r, heard_r, pinned_ok_r, beam_pinned_r, src_ok_r;
  logic          active_nxt, tracked_ok_nxt, heard_nxt, pinned_ok_nxt, beam_pinned_nxt;
  logic          src_ok_nxt;
  logic [BW-1:0] bg_r, bg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r       <= '0;
      start_r       <= '0;
      last_speech_r <= '0;
      last_dir_r    <= '0;
      src_time_r    <= '0;
      tracked_r     <= '0;
      pinned_r      <= '0;
      src_angle_r   <= '0;
      active_r      <= 1'b0;
      tracked_ok_r  <= 1'b0;
      heard_r       <= 1'b0;
      pinned_ok_r   <= 1'b0;
      beam_pinned_r <= 1'b0;
      src_ok_r      <= 1'b0;
      bg_r          <= '0;
    end else if (step) begin
      clock_r       <= clock_nxt;
      start_r       <= start_nxt;
      last_speech_r <= last_speech_nxt;
      last_dir_r    <= last_dir_nxt;
      src_time_r    <= src_time_nxt;
      tracked_r     <= tracked_nxt;
      pinned_r      <= pinned_nxt;
      src_angle_r   <= src_angle_nxt;
      active_r      <= active_nxt;
      tracked_ok_r  <= tracked_ok_nxt;
      heard_r       <= heard_nxt;
      pinned_ok_r   <= pinned_ok_nxt;
      beam_pinned_r <= beam_pinned_nxt;
      src_ok_r      <= src_ok_nxt;
      bg_r          <= bg_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Tick logic: wake handling, direction polling, then session checks
  // ---------------------------------------------------------------------
  logic [CW-1:0] now;
  logic          wake_idle, ring_by_wake, open_sess, rejected, dir_fresh, do_pin;
  logic          speech;

  // state after the wake step
  logic [CW-1:0] start_w, last_speech_w;
  logic          active_w, heard_w, src_ok_w, pinned_ok_w, beam_pinned_w;
  logic [AW-1:0] pinned_w;
  logic [BW-1:0] bg_w;

  // source direction after polling
  logic          src_take;
  logic [CW-1:0] src_time_d, src_age;
  logic [AW-1:0] src_angle_d;
  logic          src_ok_d;

  logic [AW-1:0] ang_d, ang_e, ang_min;
  logic          from_speaker, talk;
  logic [BW:0]   bg_sum;
  logic [CW-1:0] age, quiet;
  vstc_pkg::cause_t cause;
  vstc_pkg::ring_t  ring;

  assign now       = clock_r + TICK;
  assign clock_nxt = now;
  assign speech    = {1'b0, in_word_r.since_speech_ms} < SPEECH_LIM;

  assign wake_idle    = in_word_r.wake_event && !active_r;
  assign ring_by_wake = wake_idle && in_word_r.timer_ringing;
  assign open_sess    = wake_idle && !in_word_r.timer_ringing && in_word_r.room_link_up;
  assign rejected     = wake_idle && !in_word_r.timer_ringing && !in_word_r.room_link_up;
  assign dir_fresh    = tracked_ok_r && ((now - last_dir_r) <= DIR_FRESH);
  assign do_pin       = open_sess && pin_en_r && dir_fresh;

  assign active_w      = active_r || open_sess;
  assign start_w       = open_sess ? now : start_r;
  assign last_speech_w = open_sess ? now : last_speech_r;
  assign heard_w       = open_sess ? 1'b0 : heard_r;
  assign src_ok_w      = open_sess ? 1'b0 : src_ok_r;
  assign bg_w          = open_sess ? '0 : bg_r;
  assign pinned_w      = do_pin ? tracked_r : pinned_r;
  // with pinning enabled, an open without a fresh direction drops the pin
  assign pinned_ok_w   = (open_sess && pin_en_r) ? dir_fresh : pinned_ok_r;
  assign beam_pinned_w = do_pin || beam_pinned_r;

  // tracked direction: fixed beam while pinned, dominant source otherwise
  always_comb begin
    tracked_nxt    = tracked_r;
    last_dir_nxt   = last_dir_r;
    tracked_ok_nxt = tracked_ok_r;
    if (beam_pinned_w ? in_word_r.fixed_angle_ok : in_word_r.auto_angle_ok) begin
      tracked_nxt    = beam_pinned_w ? in_word_r.fixed_angle : in_word_r.auto_angle;
      last_dir_nxt   = now;
      tracked_ok_nxt = 1'b1;
    end
  end

  assign src_take    = beam_pinned_w && in_word_r.auto_angle_ok;
  assign src_angle_d = src_take ? in_word_r.auto_angle : src_angle_r;
  assign src_time_d  = src_take ? now : src_time_r;
  assign src_ok_d    = src_take || src_ok_w;
  // a sample taken this tick has age zero
  assign src_age     = src_take ? '0 : (now - src_time_r);

  // wrapped distance between source and pinned direction
  assign ang_d   = src_angle_d - pinned_w;
  assign ang_e   = AW'(0) - ang_d;
  assign ang_min = (ang_d < ang_e) ? ang_d : ang_e;

  always_comb begin
    if (!filt_en_r || !pinned_ok_w || !beam_pinned_w) begin
      from_speaker = 1'b1;
    end else if (!src_ok_d || (src_age > SRC_FRESH)) begin
      from_speaker = 1'b1;
    end else begin
      from_speaker = {{(vstc_pkg::TOL_W - AW){1'b0}}, ang_min} <= tol_r;
    end
  end

  assign talk   = active_w && speech && from_speaker;
  assign bg_sum = {1'b0, bg_w} + BG_TICK;

  always_comb begin
    last_speech_nxt = last_speech_w;
    heard_nxt       = heard_w;
    bg_nxt          = bg_w;
    if (active_w && speech) begin
      if (from_speaker) begin
        last_speech_nxt = now;
        heard_nxt       = 1'b1;
      end else begin
        bg_nxt = bg_sum[BW] ? vstc_pkg::BG_MAX : bg_sum[BW-1:0];
      end
    end
  end

  // speaker speech this tick resets the silence age to zero
  assign age   = now - start_w;
  assign quiet = talk ? '0 : (now - last_speech_w);

  always_comb begin
    cause = vstc_pkg::CAUSE_NONE;
    if (active_w) begin
      priority if (heard_nxt && (quiet > {{(CW - LW){1'b0}}, silence_lim_r})) begin
        cause = vstc_pkg::CAUSE_SILENCE;
      end else if (!heard_nxt && (age > {{(CW - LW){1'b0}}, no_speech_lim_r})) begin
        cause = vstc_pkg::CAUSE_NO_SPEECH;
      end else if (age > {{(CW - LW){1'b0}}, max_sess_r}) begin
        cause = vstc_pkg::CAUSE_TOO_LONG;
      end else if (!in_word_r.room_link_up) begin
        cause = vstc_pkg::CAUSE_LINK_LOST;
      end else begin
        cause = vstc_pkg::CAUSE_NONE;
      end
    end
  end

  // a stop by wake wins over a stop by speech in the same tick
  always_comb begin
    ring = vstc_pkg::RING_NONE;
    if (ring_by_wake) begin
      ring = vstc_pkg::RING_WAKE;
    end else if (!active_w && in_word_r.timer_ringing &&
                 ({1'b0, in_word_r.since_speech_ms} < RING_LIM)) begin
      ring = vstc_pkg::RING_SPEECH;
    end
  end

  assign active_nxt      = active_w && (cause == vstc_pkg::CAUSE_NONE);
  assign beam_pinned_nxt = beam_pinned_w && (cause == vstc_pkg::CAUSE_NONE);
  assign pinned_ok_nxt   = pinned_ok_w && (cause == vstc_pkg::CAUSE_NONE);
  assign start_nxt       = start_w;
  assign pinned_nxt      = pinned_w;
  assign src_angle_nxt   = src_angle_d;
  assign src_time_nxt    = src_time_d;
  assign src_ok_nxt      = src_ok_d;

  always_comb begin
    out_word_nxt.session_on     = active_nxt;
    out_word_nxt.session_opened = open_sess;
    out_word_nxt.close_cause    = cause;
    out_word_nxt.ring_stop      = ring;
    out_word_nxt.wake_rejected  = rejected;
    out_word_nxt.pin_command    = do_pin;
    out_word_nxt.unpin_command  = beam_pinned_w && (cause != vstc_pkg::CAUSE_NONE);
    out_word_nxt.pin_angle      = do_pin ? tracked_r : '0;
    out_word_nxt.shown_angle    = tracked_nxt;
    out_word_nxt.shown_angle_ok = tracked_ok_nxt;
    out_word_nxt.speaker_heard  = heard_nxt;
    out_word_nxt.background_ms  = bg_nxt;
  end

  // ---------------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------------
  assign out_valid          = out_valid_r;
  assign out_session_on     = out_word_r.session_on;
  assign out_session_opened = out_word_r.session_opened;
  assign out_close_cause    = out_word_r.close_cause;
  assign out_ring_stop      = out_word_r.ring_stop;
  assign out_wake_rejected  = out_word_r.wake_rejected;
  assign out_pin_command    = out_word_r.pin_command;
  assign out_unpin_command  = out_word_r.unpin_command;
  assign out_pin_angle      = out_word_r.pin_angle;
  assign out_shown_angle    = out_word_r.shown_angle;
  assign out_shown_angle_ok = out_word_r.shown_angle_ok;
  assign out_speaker_heard  = out_word_r.speaker_heard;
  assign out_background_ms  = out_word_r.background_ms;

endmodule
